### hdl/cce_pkg.sv
`timescale 1ns / 1ps
package cce_pkg;

  localparam int REPEAT_BITS = 16;
  localparam int LENGTH_BITS = 31;

  localparam logic [31:0] POLY_RESET = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FN_BYTE   = 2'd0,
    FN_REPEAT = 2'd1,
    FN_COMB   = 2'd2,
    FN_INIT   = 2'd3
  } func_t;

  typedef enum logic {
    CFG_POLY = 1'b0,
    CFG_MSB  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REP,
    ST_SQ,
    ST_APPLY
  } state_t;

  typedef logic [31:0][31:0] gf2_mat_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[i] = v[31-i];
    return r;
  endfunction

  // reflected table entry, eight conditional shifts
  function automatic logic [31:0] refl_entry(input logic [7:0] idx, input logic [31:0] poly);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    return c;
  endfunction

  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b,
                                            input logic [31:0] poly, input logic msb);
    logic [7:0] t;
    if (msb) begin
      t = crc[31:24] ^ b;
      return (crc << 8) ^ rev32(refl_entry(rev8(t), poly));
    end else begin
      t = crc[7:0] ^ b;
      return (crc >> 8) ^ refl_entry(t, poly);
    end
  endfunction

endpackage

### hdl/cce_if.sv
`timescale 1ns / 1ps
interface cce_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      func;
  logic [7:0]                      data_byte;
  logic [cce_pkg::REPEAT_BITS-1:0] repeat_count;
  logic [31:0]                     other_crc;
  logic [cce_pkg::LENGTH_BITS-1:0] other_length;
  modport source (output valid, func, data_byte, repeat_count, other_crc, other_length,
                  input ready);
  modport sink (input valid, func, data_byte, repeat_count, other_crc, other_length,
                output ready);
endinterface

interface cce_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  modport source (output valid, crc_value, input ready);
  modport sink (input valid, crc_value, output ready);
endinterface

### hdl/cce_gf2_mul.sv
`timescale 1ns / 1ps
module cce_gf2_mul
  import cce_pkg::*;
(
  input  gf2_mat_t    mat,
  input  logic [31:0] vec,
  output logic [31:0] prod
);
  // xor of the rows picked by the set bits of vec
  always_comb begin
    prod = '0;
    for (int i = 0; i < 32; i++) begin
      if (vec[i]) prod = prod ^ mat[i];
    end
  end
endmodule

### hdl/crc32_engine_with_combine.sv
`timescale 1ns / 1ps
// channel  dir  handshake           payload
// in_ch    in   valid/ready         func, data_byte, repeat_count, other_crc, other_length
// out_ch   out  valid/ready         crc_value
// cfg      in   cfg_we only         cfg_index, cfg_data
//
// byte update and reset: result registered next cycle
// repeated byte: accept, then repeat_count folds in ST_REP (result straight from accept if zero)
// combine: each operator squaring runs row by row through the shared gf2 multiplier,
//   (2 + bit length of other_length) squarings plus one ST_APPLY step per length bit
// a new item is taken while a result waits only if that result leaves the same cycle
// rst is synchronous: crc register all ones, polynomial IEEE reflected, msb_first clear
module crc32_engine_with_combine
  import cce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cce_in_if.sink      in_ch,
  cce_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;

  logic [31:0] poly;
  logic        msb;
  logic [31:0] crc, crc_next;
  logic        out_valid, out_valid_next;
  logic [31:0] out_crc, out_crc_next;

  // loop registers for repeat and combine
  logic [REPEAT_BITS-1:0] rep_cnt, rep_cnt_next;
  logic [7:0]             rep_byte, rep_byte_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  logic [31:0]            other, other_next;
  logic [31:0]            c1, c1_next;
  logic [4:0]             row, row_next;
  logic [1:0]             pre_cnt, pre_cnt_next;
  logic                   sel, sel_next;

  // two matrix banks, ping-pong between source and destination of a squaring
  gf2_mat_t mat_a, mat_b;
  gf2_mat_t src_mat;
  logic [31:0] mul_vec, mul_out;
  logic        accept, out_free;

  assign src_mat = sel ? mat_b : mat_a;
  assign mul_vec = (state == ST_SQ) ? src_mat[row] : c1;

  cce_gf2_mul u_mul (
    .mat  (src_mat),
    .vec  (mul_vec),
    .prod (mul_out)
  );

  assign out_free     = !out_valid || out_ch.ready;
  assign in_ch.ready  = (state == ST_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.crc_value = out_crc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= POLY_RESET;
      msb  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POLY: poly <= cfg_data;
        CFG_MSB:  msb  <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      crc       <= CRC_ONES;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      crc       <= crc_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_crc  <= out_crc_next;
    rep_cnt  <= rep_cnt_next;
    rep_byte <= rep_byte_next;
    len      <= len_next;
    other    <= other_next;
    c1       <= c1_next;
    row      <= row_next;
    pre_cnt  <= pre_cnt_next;
    sel      <= sel_next;
  end

  // matrix banks: load at combine start, one row per squaring cycle
  always_ff @(posedge clk) begin
    if (accept && func_t'(in_ch.func) == FN_COMB) begin
      mat_a[0] <= poly;
      for (int i = 1; i < 32; i++) mat_a[i] <= 32'd1 << (i - 1);
    end else if (state == ST_SQ) begin
      if (sel) mat_a[row] <= mul_out;
      else     mat_b[row] <= mul_out;
    end
  end

  always_comb begin
    state_next     = state;
    crc_next       = crc;
    out_valid_next = out_valid && !out_ch.ready;
    out_crc_next   = out_crc;
    rep_cnt_next   = rep_cnt;
    rep_byte_next  = rep_byte;
    len_next       = len;
    other_next     = other;
    c1_next        = c1;
    row_next       = row;
    pre_cnt_next   = pre_cnt;
    sel_next       = sel;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_ch.func))
            FN_BYTE: begin
              crc_next       = fold_byte(crc, in_ch.data_byte, poly, msb);
              out_valid_next = 1'b1;
              out_crc_next   = ~crc_next;
            end
            FN_REPEAT: begin
              if (in_ch.repeat_count == '0) begin
                out_valid_next = 1'b1;
                out_crc_next   = ~crc;
              end else begin
                rep_cnt_next  = in_ch.repeat_count;
                rep_byte_next = in_ch.data_byte;
                state_next    = ST_REP;
              end
            end
            FN_COMB: begin
              if (in_ch.other_length == '0) begin
                out_valid_next = 1'b1;
                out_crc_next   = ~crc;
              end else begin
                len_next     = in_ch.other_length;
                other_next   = in_ch.other_crc;
                c1_next      = ~crc;
                row_next     = '0;
                pre_cnt_next = '0;
                sel_next     = 1'b0;
                state_next   = ST_SQ;
              end
            end
            FN_INIT: begin
              crc_next       = CRC_ONES;
              out_valid_next = 1'b1;
              out_crc_next   = '0;
            end
          endcase
        end
      end
      ST_REP: begin
        crc_next     = fold_byte(crc, rep_byte, poly, msb);
        rep_cnt_next = rep_cnt - 1'b1;
        if (rep_cnt == REPEAT_BITS'(1)) begin
          out_valid_next = 1'b1;
          out_crc_next   = ~crc_next;
          state_next     = ST_IDLE;
        end
      end
      ST_SQ: begin
        row_next = row + 1'b1;
        if (row == 5'd31) begin
          sel_next = !sel;
          if (pre_cnt != 2'd2) pre_cnt_next = pre_cnt + 1'b1;
          else                 state_next   = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (len[0]) c1_next = mul_out;
        len_next = len >> 1;
        row_next = '0;
        if (len_next == '0) begin
          crc_next       = ~(c1_next ^ other);
          out_valid_next = 1'b1;
          out_crc_next   = ~crc_next;
          state_next     = ST_IDLE;
        end else begin
          state_next = ST_SQ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // the repeated byte is latched at accept, the source may move on meanwhile

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid) else $error("result pending while busy");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (state == ST_IDLE)) else $error("ready while busy");
  a_pre_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ) |-> (pre_cnt != 2'd3)) else $error("squaring count overrun");
  a_apply_after_sq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> ($past(state) == ST_SQ)) else $error("apply without squaring");

endmodule
